[hw/rtl/sstf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_pkg: shared types and codes of the seek scheduler
// Word formats of both channels, the internal command word and status codes.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int FIELD_W = 10;
    localparam int OCC_W   = 7;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SERVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_SERVE     = 2'd1,
        OP_REJ_EMPTY = 2'd2,
        OP_REJ_FULL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] track;
        logic [FIELD_W-1:0] head_track;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] served_track;
        logic [FIELD_W-1:0] seek_distance;
        logic [OCC_W-1:0]   occupancy;
    } t_out_word;

    // The track field carries the new track for an add and the head for a serve.
    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] track;
    } t_cmd;

endpackage
`default_nettype wire

[hw/rtl/sstf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hw/rtl/sstf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_front: request intake and classification
// Tracks the occupancy the queue will have and turns each word into a command.
// ----------------------------------------------------------------------------
module sstf_front #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sstf_pkg::t_in_word i_item,
    output logic              o_full,
    input  logic              i_cmd_full,
    output logic              o_cmd_push,
    output sstf_pkg::t_cmd    o_cmd
);

    import sstf_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    always_comb begin
        n_count     = r_count;
        o_cmd.op    = OP_ADD;
        o_cmd.track = i_item.track;
        if (i_item.req_type == REQ_ADD) begin
            if (r_count == DEPTH_C) begin
                o_cmd.op = OP_REJ_FULL;
            end else begin
                o_cmd.op = OP_ADD;
                n_count  = r_count + 1'b1;
            end
        end else begin
            o_cmd.track = i_item.head_track;
            if (r_count == '0) begin
                o_cmd.op = OP_REJ_EMPTY;
            end else begin
                o_cmd.op = OP_SERVE;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_cmd_push) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sstf_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_cmd_fifo: two-word command queue
// Decouples classification from execution so either side can stall alone.
// ----------------------------------------------------------------------------
module sstf_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sstf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sstf_pkg::t_cmd o_cmd
);

    import sstf_pkg::*;

    localparam logic [1:0] FIFO_DEPTH = 2'd2;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_used;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_used == FIFO_DEPTH);
    assign o_empty = (r_used == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_used   <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_used <= r_used + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sstf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_back: request store and nearest-track search
// Appends adds to memory; a serve scans all entries, then refills the hole.
// ----------------------------------------------------------------------------
module sstf_back #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  sstf_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output sstf_pkg::t_out_word o_result
);

    import sstf_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int TW = FIELD_W;

    t_back_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_issue, n_issue;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic [TW-1:0] r_head, n_head;
    logic [TW-1:0] r_best_t, n_best_t;
    logic [TW-1:0] r_best_d, n_best_d;
    logic [TW-1:0] r_last_t, n_last_t;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic          r_have, n_have;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    logic          w_out_free;
    logic          w_take;
    logic          w_scan_done;
    logic          w_better;
    logic [TW-1:0] w_rd_data;
    logic [TW-1:0] w_dist;
    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic [TW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;

    sstf_ram #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free  = !r_out_valid || i_pop;
    assign w_take      = (r_state == BK_IDLE) && !i_cmd_empty && w_out_free;
    assign o_cmd_pop   = w_take;
    assign w_scan_done = (r_issue == r_count) && !r_pend;
    assign ram_rd_addr = AW'(r_issue);
    assign w_dist      = (w_rd_data >= r_head) ? (w_rd_data - r_head) : (r_head - w_rd_data);
    assign w_better    = !r_have || (w_dist < r_best_d)
                         || ((w_dist == r_best_d) && (w_rd_data < r_best_t));
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_take && (i_cmd.op == OP_SERVE)) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (w_scan_done) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_head      = r_head;
        n_best_t    = r_best_t;
        n_best_d    = r_best_d;
        n_best_idx  = r_best_idx;
        n_last_t    = r_last_t;
        n_have      = r_have;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wr_addr = AW'(r_count);
        ram_wr_data = TW'(i_cmd.track);
        case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    n_out.served_track  = '0;
                    n_out.seek_distance = '0;
                    case (i_cmd.op)
                        OP_ADD: begin
                            ram_we          = 1'b1;
                            n_count         = r_count + 1'b1;
                            n_out.status    = ST_ADDED;
                            n_out.occupancy = OCC_W'(r_count + 1'b1);
                            n_out_valid     = 1'b1;
                        end
                        OP_SERVE: begin
                            n_head  = TW'(i_cmd.track);
                            n_issue = '0;
                            n_pend  = 1'b0;
                            n_have  = 1'b0;
                        end
                        OP_REJ_EMPTY: begin
                            n_out.status    = ST_EMPTY;
                            n_out.occupancy = OCC_W'(r_count);
                            n_out_valid     = 1'b1;
                        end
                        OP_REJ_FULL: begin
                            n_out.status    = ST_FULL;
                            n_out.occupancy = OCC_W'(r_count);
                            n_out_valid     = 1'b1;
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_pop;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                if (r_issue != r_count) begin
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = AW'(r_issue);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_better) begin
                        n_best_t   = w_rd_data;
                        n_best_d   = w_dist;
                        n_best_idx = r_pend_idx;
                        n_have     = 1'b1;
                    end
                    if (r_pend_idx == AW'(r_count - 1'b1)) begin
                        n_last_t = w_rd_data;
                    end
                end
            end
            BK_FINISH: begin
                ram_we              = 1'b1;
                ram_wr_addr         = r_best_idx;
                ram_wr_data         = r_last_t;
                n_count             = r_count - 1'b1;
                n_out.status        = ST_SERVED;
                n_out.served_track  = FIELD_W'(r_best_t);
                n_out.seek_distance = FIELD_W'(r_best_d);
                n_out.occupancy     = OCC_W'(r_count - 1'b1);
                n_out_valid         = 1'b1;
            end
            default: begin
                n_out_valid = r_out_valid && !i_pop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_head     <= n_head;
        r_best_t   <= n_best_t;
        r_best_d   <= n_best_d;
        r_best_idx <= n_best_idx;
        r_last_t   <= n_last_t;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

[hw/rtl/sstf_request_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_request_queue_core: shortest-seek-time-first request scheduler
// Holds pending track requests and serves the one nearest the head.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Word
// request   in         push / full        i_item   (t_in_word)
// result    out        empty / pop        o_result (t_out_word)
//
// With the command queue and the search unit idle, an add or a rejected
// request passes through the command queue into the result register.
// A serve shows its result word once the memory has been scanned one entry
// per cycle on its single read port and the hole refilled. Reset empties
// the queue at once through the entry count.
// full rises while both slots of the two-word command queue hold a word; a
// result word not yet popped holds the search unit, while up to two more
// requests are taken.
// ----------------------------------------------------------------------------
module sstf_request_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  sstf_pkg::t_in_word  i_item,
    output logic                full,
    output logic                empty,
    output sstf_pkg::t_out_word o_result,
    input  logic                pop
);

    import sstf_pkg::*;

    logic w_cmd_push;
    logic w_cmd_full;
    logic w_cmd_pop;
    logic w_cmd_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    sstf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_cmd_full (w_cmd_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    sstf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    sstf_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

[hw/rtl/sstf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_checker: port-level checks of the seek scheduler
// Watches both channels and the reported occupancy from word to word.
// ----------------------------------------------------------------------------
module sstf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input sstf_pkg::t_out_word o_result,
    input logic                pop
);

    import sstf_pkg::*;

    logic [2:0]       r_in_flight;
    logic [OCC_W-1:0] r_last_occ;
    logic [OCC_W-1:0] w_exp_occ;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = push && !full;
    assign w_out_acc = pop && !empty;

    always_comb begin
        case (o_result.status)
            ST_ADDED:  w_exp_occ = r_last_occ + 1'b1;
            ST_SERVED: w_exp_occ = r_last_occ - 1'b1;
            default:   w_exp_occ = r_last_occ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= 3'd0;
            r_last_occ  <= '0;
        end else begin
            r_in_flight <= r_in_flight + {2'b00, w_in_acc} - {2'b00, w_out_acc};
            if (w_out_acc) begin
                r_last_occ <= o_result.occupancy;
            end
        end
    end

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not idle after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result word changed while waiting");

    a_result_has_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_in_flight != 3'd0))
        else $error("result word without an accepted request");

    a_occupancy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (o_result.occupancy == w_exp_occ))
        else $error("occupancy does not follow the status sequence");

endmodule

bind sstf_request_queue_core sstf_checker u_sstf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .o_result (o_result),
    .pop      (pop)
);
`default_nettype wire
